/* design/stable_sorted_priority_queue_unit_assert.svh */
// ----------------------------------------------------------------------------
// stable sorted priority queue - assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SSPQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sspq: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SSPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sspq: next-cycle check failed");

`endif

/* design/sspq_pkg.sv */
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and constants shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sspq_pkg;

   // queue geometry, fixed by the widths of the transfer fields
   localparam int DEPTH         = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int PAYLOAD_BITS  = 32;
   localparam int CNT_BITS      = 5;

   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

   // command codes
   typedef enum logic [1:0] {
      CMD_ENQ   = 2'd0,
      CMD_DEQ   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // request transfer
   typedef struct packed {
      cmd_type                  cmd;
      logic [PRIORITY_BITS-1:0] priority_req;
      logic [PAYLOAD_BITS-1:0]  payload;
   } req_type;

   // response transfer
   typedef struct packed {
      logic                     data_valid;
      logic [PAYLOAD_BITS-1:0]  data_out;
      logic                     head_valid;
      logic [PRIORITY_BITS-1:0] head_priority;
      logic [PAYLOAD_BITS-1:0]  head_data;
      logic [CNT_BITS-1:0]      count;
      logic                     overflow;
   } rsp_type;

   // one stored entry
   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [PAYLOAD_BITS-1:0]  data;
   } entry_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic enq;
      logic deq;
   } ctl_type;

endpackage

`default_nettype wire

/* design/sspq_cell.sv */
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted queue: holds an entry, compares it with the incoming
// priority and takes its own, its left or right neighbour's or the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sspq_cell (
   input  wire                        clock,
   input  wire sspq_pkg::ctl_type     ctl,
   input  wire                        occ,
   input  wire sspq_pkg::entry_type   new_entry,
   input  wire sspq_pkg::entry_type   left_entry,
   input  wire                        left_gt,
   input  wire sspq_pkg::entry_type   right_entry,
   output sspq_pkg::entry_type        entry_out,
   output logic                       gt_out
);
   import sspq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // new entry goes ahead of this slot when the slot is free or strictly larger
   assign gt_out = !occ || (entry_ff.prio > new_entry.prio);

   // slot update: shift right on insert, shift left on removal
   always_comb begin
      entry_in = entry_ff;
      if (ctl.enq) begin
         if (gt_out && left_gt) begin
            entry_in = left_entry;
         end else if (gt_out) begin
            entry_in = new_entry;
         end
      end else if (ctl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

`default_nettype wire

/* design/stable_sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Bounded priority queue held in ascending order in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer: enqueue a priority and payload,
//   dequeue the head, or query. Equal priorities leave in arrival order.
//   rsp_* returns one result per request: the removed payload on dequeue,
//   the head entry and count after the step, and an overflow flag when an
//   enqueue finds all slots in use (the queue is then left unchanged).
//   The result is registered at the edge the request transfers. Throughput
//   is one request per cycle while rsp_ready is high; every slot compares
//   with the new priority in parallel, so an insert or removal completes
//   in one cell update.
//   While a result waits for rsp_ready, req_ready is low; a new request is
//   taken in the same cycle as the waiting result transfers.
//   Reset empties the queue (count zero) and drops any pending result; slot
//   contents are not cleared and are never shown until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stable_sorted_priority_queue_unit_assert.svh"

module stable_sorted_priority_queue_unit (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire sspq_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output sspq_pkg::rsp_type       rsp_data
);
   import sspq_pkg::*;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic                     data_valid_ff, data_valid_in;
   logic [PAYLOAD_BITS-1:0]  data_out_ff, data_out_in;
   logic                     overflow_ff, overflow_in;
   logic                     req_fire;
   logic                     full, empty;
   ctl_type                  ctl;
   entry_type                new_entry;
   entry_type                cell_q [DEPTH];
   logic [DEPTH-1:0]         cell_gt;
   logic [DEPTH-1:0]         cell_occ;

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign new_entry = '{prio: req_data.priority_req, data: req_data.payload};

   // command decode
   always_comb begin
      ctl           = '0;
      count_in      = count_ff;
      data_valid_in = 1'b0;
      data_out_in   = '0;
      overflow_in   = 1'b0;
      if (req_fire) begin
         unique case (req_data.cmd)
            CMD_ENQ: begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  ctl.enq  = 1'b1;
                  count_in = count_ff + CNT_ONE;
               end
            end
            CMD_DEQ: begin
               if (!empty) begin
                  ctl.deq       = 1'b1;
                  count_in      = count_ff - CNT_ONE;
                  data_valid_in = 1'b1;
                  data_out_in   = cell_q[0].data;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result valid: set on a request transfer, cleared once taken
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         data_valid_ff <= data_valid_in;
         data_out_ff   <= data_out_in;
         overflow_ff   <= overflow_in;
      end
   end

   // row of cells, slot 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_gt;

      assign cell_occ[i] = (count_ff > CNT_BITS'(i));

      if (i == 0) begin : g_head
         assign left_entry = new_entry;
         assign left_gt    = 1'b0;
      end else begin : g_mid
         assign left_entry = cell_q[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_q[i];
      end else begin : g_body
         assign right_entry = cell_q[i+1];
      end

      sspq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occ         (cell_occ[i]),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .entry_out   (cell_q[i]),
         .gt_out      (cell_gt[i])
      );
   end

   // response; head fields follow the cells, which hold while a result waits
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.data_valid     = data_valid_ff;
   assign rsp_data.data_out       = data_out_ff;
   assign rsp_data.head_valid     = !empty;
   assign rsp_data.head_priority  = empty ? '0 : cell_q[0].prio;
   assign rsp_data.head_data      = empty ? '0 : cell_q[0].data;
   assign rsp_data.count          = count_ff;
   assign rsp_data.overflow       = overflow_ff;

   // checks
   `SSPQ_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_FULL)
   `SSPQ_ASSERT_SAME(a_overflow_full, rsp_valid_ff && overflow_ff, full)
   `SSPQ_ASSERT_NEXT(a_deq_count,
      req_fire && (req_data.cmd == CMD_DEQ) && !empty,
      count_ff == $past(count_ff) - CNT_ONE)
   `SSPQ_ASSERT_SAME(a_head_order, count_ff > CNT_ONE, cell_q[0].prio <= cell_q[1].prio)

endmodule

`default_nettype wire

/* bench/stable_sorted_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit_tb
// Self-checking bench for the sorted priority queue. A clocked driver offers
// requests from a backlog filled at time zero, and a shadow copy of the queue
// predicts each result. A clocked monitor checks every result transfer field
// by field against the oldest prediction. Both sides idle at random. The
// receiver holds off for long stretches so that the input stalls, and the
// sender pauses at times until the queue of predictions has drained.
// ----------------------------------------------------------------------------

module stable_sorted_priority_queue_unit_tb;
   import sspq_pkg::*;

   // spare command encoding, behaves as a query
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 1000;
   localparam int         LONG_HOLD    = 48;
   localparam int         MAX_REPORTS  = 10;

   typedef struct {
      req_type     item;
      int unsigned gap;
      bit          drain_first;
   } offer_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   offer_type req_backlog[$];
   rsp_type   pending_results[$];

   // shadow copy of the queue contents, slot 0 is the head
   logic [PRIORITY_BITS-1:0] shadow_prio [DEPTH];
   logic [PAYLOAD_BITS-1:0]  shadow_data [DEPTH];
   int                       shadow_fill = 0;

   int unsigned mismatches  = 0;
   int unsigned rsp_seen    = 0;
   int unsigned tx_wait     = 0;
   int unsigned rx_wait     = 0;
   int unsigned n_enq       = 0;
   int unsigned n_overflow  = 0;
   int unsigned n_deq_hit   = 0;
   int unsigned n_deq_empty = 0;
   int unsigned n_query     = 0;
   int          peak_fill   = 0;

   stable_sorted_priority_queue_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // apply one request to the shadow queue and return the result it causes
   function automatic rsp_type next_queue_result(req_type r);
      rsp_type res;
      int      pos;
      int      i;
      res = '0;
      if (r.cmd == CMD_ENQ) begin
         if (shadow_fill >= DEPTH) begin
            res.overflow = 1'b1;
            n_overflow++;
         end else begin
            // stable insert: after every entry of lower or equal priority
            pos = 0;
            while (pos < shadow_fill && shadow_prio[pos] <= r.priority_req) pos++;
            for (i = shadow_fill; i > pos; i--) begin
               shadow_prio[i] = shadow_prio[i-1];
               shadow_data[i] = shadow_data[i-1];
            end
            shadow_prio[pos] = r.priority_req;
            shadow_data[pos] = r.payload;
            shadow_fill++;
            n_enq++;
            if (shadow_fill > peak_fill) peak_fill = shadow_fill;
         end
      end else if (r.cmd == CMD_DEQ) begin
         if (shadow_fill > 0) begin
            res.data_valid = 1'b1;
            res.data_out   = shadow_data[0];
            for (i = 1; i < shadow_fill; i++) begin
               shadow_prio[i-1] = shadow_prio[i];
               shadow_data[i-1] = shadow_data[i];
            end
            shadow_fill--;
            n_deq_hit++;
         end else begin
            n_deq_empty++;
         end
      end else begin
         n_query++;
      end
      if (shadow_fill > 0) begin
         res.head_valid    = 1'b1;
         res.head_priority = shadow_prio[0];
         res.head_data     = shadow_data[0];
      end
      res.count = CNT_BITS'(shadow_fill);
      return res;
   endfunction

   // compare one result transfer with the oldest prediction
   task automatic check_result(rsp_type got);
      rsp_type want;
      bit      bad;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("result %0d arrived with no prediction waiting", rsp_seen);
      end else begin
         want = pending_results.pop_front();
         bad  = (got.data_valid    !== want.data_valid)    ||
                (got.data_out      !== want.data_out)      ||
                (got.head_valid    !== want.head_valid)    ||
                (got.head_priority !== want.head_priority) ||
                (got.head_data     !== want.head_data)     ||
                (got.count         !== want.count)         ||
                (got.overflow      !== want.overflow);
         if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("result %0d mismatch", rsp_seen);
               $display("  expected dv=%b out=%h hv=%b hp=%h hd=%h cnt=%0d ovf=%b",
                        want.data_valid, want.data_out, want.head_valid,
                        want.head_priority, want.head_data, want.count, want.overflow);
               $display("  actual   dv=%b out=%h hv=%b hp=%h hd=%h cnt=%0d ovf=%b",
                        got.data_valid, got.data_out, got.head_valid,
                        got.head_priority, got.head_data, got.count, got.overflow);
            end
         end
      end
   endtask

   // add one request to the backlog
   function automatic void offer(logic [1:0] cmd, logic [PRIORITY_BITS-1:0] prio,
                                 logic [PAYLOAD_BITS-1:0] data, int unsigned gap,
                                 bit drain_first);
      offer_type o;
      o.item.cmd          = cmd_type'(cmd);
      o.item.priority_req = prio;
      o.item.payload      = data;
      o.gap               = gap;
      o.drain_first       = drain_first;
      req_backlog.push_back(o);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         // a transfer took place at this edge
         if (req_valid && req_ready) begin
            pending_results.push_back(next_queue_result(req_data));
            void'(req_backlog.pop_front());
            if (req_backlog.size() != 0) tx_wait = req_backlog[0].gap;
         end
         if (req_valid && !req_ready) begin
            // hold the offered item until it is taken
         end else if (req_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (req_backlog[0].drain_first && pending_results.size() != 0) begin
            req_valid <= 1'b0;
         end else if (tx_wait != 0) begin
            req_valid <= 1'b0;
            tx_wait--;
         end else begin
            req_valid <= 1'b1;
            req_data  <= req_backlog[0].item;
         end
      end
   end

   // result monitor with its own stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
            rsp_seen++;
            if (rsp_seen == 300 || rsp_seen == 700)
               rx_wait = LONG_HOLD;
            else if ((rsp_seen / 80) % 4 == 2)
               rx_wait = 0;
            else
               rx_wait = $urandom_range(0, 7);
         end
         if (rx_wait != 0) begin
            rsp_ready <= 1'b0;
            rx_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int          i;
      int          mode;
      int          roll;
      int          pick;
      logic [1:0]  cmd;
      logic [15:0] prio;

      // directed: empty queue cases and the spare command
      offer(CMD_QUERY, 16'h0000, 32'h0000_0000, 0, 0);
      offer(CMD_DEQ, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
      offer(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
      // extremes and ties at both ends and in the middle
      offer(CMD_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
      offer(CMD_ENQ, 16'h0000, 32'h0000_0000, 0, 0);
      offer(CMD_ENQ, 16'h0005, 32'h0000_0001, 1, 0);
      offer(CMD_ENQ, 16'h0005, 32'h0000_0002, 0, 0);
      offer(CMD_ENQ, 16'h0005, 32'h0000_0003, 2, 0);
      offer(CMD_ENQ, 16'hFFFF, 32'hA5A5_A5A5, 0, 0);
      offer(CMD_ENQ, 16'h0000, 32'h5A5A_5A5A, 0, 0);
      // fill to the last slot, then one enqueue too many
      for (i = 0; i < 9; i++)
         offer(CMD_ENQ, 16'($urandom), $urandom, $urandom_range(0, 7), 0);
      offer(CMD_ENQ, 16'h0001, 32'hDEAD_BEEF, 0, 0);
      offer(CMD_QUERY, 16'h1234, 32'h1234_5678, 0, 0);
      offer(CMD_DEQ, 16'h0000, 32'h0000_0000, 0, 0);
      offer(CMD_DEQ, 16'h0000, 32'h0000_0000, 3, 0);
      offer(CMD_DEQ, 16'h0000, 32'h0000_0000, 0, 0);

      // random: phases that lean towards filling, draining or balance
      mode = 0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) mode = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         if (mode == 0)
            cmd = (roll < 75) ? CMD_ENQ : (roll < 90) ? CMD_DEQ :
                  (roll < 95) ? CMD_QUERY : CMD_UNUSED;
         else if (mode == 1)
            cmd = (roll < 20) ? CMD_ENQ : (roll < 92) ? CMD_DEQ :
                  (roll < 97) ? CMD_QUERY : CMD_UNUSED;
         else
            cmd = (roll < 46) ? CMD_ENQ : (roll < 92) ? CMD_DEQ :
                  (roll < 96) ? CMD_QUERY : CMD_UNUSED;
         // narrow ranges make ties common
         pick = $urandom_range(0, 9);
         if (pick < 3)
            prio = 16'($urandom_range(0, 3));
         else if (pick == 3)
            prio = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         else
            prio = 16'($urandom);
         offer(cmd, prio, $urandom,
               ((i / 64) % 4 == 3) ? 0 : $urandom_range(0, 7),
               (i == 200 || i == 500 || i == 800));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d results: %0d inserts, %0d full rejects, peak fill %0d",
               rsp_seen, n_enq, n_overflow, peak_fill);
      $display("removals %0d, removals from empty %0d, queries %0d, mismatches %0d",
               n_deq_hit, n_deq_empty, n_query, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("FAILURE");
      $finish;
   end

endmodule
